/* rtl/core/count_to_led_digit_writes_core_defines.svh */
// Assertion macros for the count to LED digit writes core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef COUNT_TO_LED_DIGIT_WRITES_CORE_DEFINES_SVH
`define COUNT_TO_LED_DIGIT_WRITES_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// implication or plain property, checked every clock outside reset
`define CLTD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition that must never be seen outside reset
`define CLTD_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define CLTD_ASSERT(lbl, clk, rstn, prop, msg)
`define CLTD_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* rtl/core/cltd_pkg.sv */
// Shared constants, types and tables for the count to LED digit writes core.
// No dependencies; used by cltd_queue, cltd_digit_seq and the top level.
package cltd_pkg;

    localparam int NUM_DIGITS = 8;
    localparam int COUNT_W    = 32;
    localparam int ADDR_W     = 4;
    localparam int VALUE_W    = 8;
    localparam int POS_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    localparam int                Q_DEPTH = 2;
    localparam int                Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int                Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int                DEC_BASE   = 10;
    localparam int                SEP_GROUP  = 3;
    localparam logic [3:0]        BLANK_CODE = 4'b1111;
    // ceil(2^35 / 10): quotient of any 32-bit value is (x * RECIP10) >> 35
    localparam logic [COUNT_W-1:0] RECIP10   = 32'hCCCC_CCCD;
    localparam int                RECIP_SH   = 35;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // separator point on every digit whose position is a nonzero multiple of three
    function automatic logic [NUM_DIGITS-1:0] sep_mask_f();
        logic [NUM_DIGITS-1:0] m;
        m = '0;
        for (int i = 1; i < NUM_DIGITS; i++) begin
            if ((i % SEP_GROUP) == 0) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    localparam logic [NUM_DIGITS-1:0] SEP_MASK = sep_mask_f();

endpackage

/* rtl/core/cltd_queue.sv */
// Short count queue between the accepting front and the digit sequencer.
// Depends on cltd_pkg and the assertion macros in the defines header.
`include "count_to_led_digit_writes_core_defines.svh"

module cltd_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [cltd_pkg::COUNT_W-1:0]  i_data,
    input  logic                          i_pop,
    output logic [cltd_pkg::COUNT_W-1:0]  o_head,
    output cltd_pkg::t_q_status           o_status
);

    logic [cltd_pkg::COUNT_W-1:0] r_mem [cltd_pkg::Q_DEPTH];
    logic [cltd_pkg::Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [cltd_pkg::Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [cltd_pkg::Q_CNT_W-1:0] r_count, n_count;

    // pointers wrap at the depth, which need not be a power of two
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == cltd_pkg::Q_PTR_W'(cltd_pkg::Q_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == cltd_pkg::Q_PTR_W'(cltd_pkg::Q_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == cltd_pkg::Q_CNT_W'(cltd_pkg::Q_DEPTH));

    `CLTD_NEVER(a_q_overflow, i_clk, i_rst_n, i_push && o_status.full && !i_pop,
        "queue written while full")
    `CLTD_NEVER(a_q_underflow, i_clk, i_rst_n, i_pop && o_status.empty,
        "queue read while empty")

endmodule

/* rtl/core/cltd_digit_seq.sv */
// Digit sequencer: splits one count into decimal digits, one write per cycle.
// Depends on cltd_pkg and the assertion macros in the defines header.
`include "count_to_led_digit_writes_core_defines.svh"

module cltd_digit_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cltd_pkg::t_q_status           i_q_status,
    input  logic [cltd_pkg::COUNT_W-1:0]  i_head,
    output logic                          o_pop,
    output logic                          o_strobe,
    output logic [cltd_pkg::ADDR_W-1:0]   o_digit_address,
    output logic [cltd_pkg::VALUE_W-1:0]  o_digit_value,
    output logic                          o_last_write
);

    logic                           r_active, n_active;
    logic [cltd_pkg::COUNT_W-1:0]   r_rest, n_rest;
    logic [cltd_pkg::POS_W-1:0]     r_pos, n_pos;

    logic                           r_strobe;
    logic [cltd_pkg::ADDR_W-1:0]    r_addr;
    logic [cltd_pkg::VALUE_W-1:0]   r_value;
    logic                           r_last;

    logic [2*cltd_pkg::COUNT_W-1:0] prod;
    logic [cltd_pkg::COUNT_W-1:0]   quot;
    logic [cltd_pkg::COUNT_W-1:0]   rem_full;
    logic [3:0]                     digit;
    logic                           at_last;
    logic                           blank;
    logic [cltd_pkg::VALUE_W-1:0]   code;

    // divide by ten through the reciprocal; remainder is rest - 8q - 2q
    always_comb begin
        prod     = {{cltd_pkg::COUNT_W{1'b0}}, r_rest} *
                   {{cltd_pkg::COUNT_W{1'b0}}, cltd_pkg::RECIP10};
        quot     = cltd_pkg::COUNT_W'(prod >> cltd_pkg::RECIP_SH);
        rem_full = r_rest - (quot << 3) - (quot << 1);
        digit    = rem_full[3:0];
        at_last  = (r_pos == cltd_pkg::POS_W'(cltd_pkg::NUM_DIGITS - 1));
        // leading zero: nothing left above this digit, not the first digit
        blank    = (digit == 4'd0) && (quot == '0) && (r_pos != '0);
        code     = blank ? {4'b0000, cltd_pkg::BLANK_CODE}
                         : {cltd_pkg::SEP_MASK[r_pos], 3'b000, digit};
    end

    // next count is popped while the final digit is formed, so runs abut
    always_comb begin
        o_pop    = !i_q_status.empty && (!r_active || at_last);
        n_active = r_active;
        n_rest   = r_rest;
        n_pos    = r_pos;
        if (o_pop) begin
            n_active = 1'b1;
            n_rest   = i_head;
            n_pos    = '0;
        end else if (r_active) begin
            if (at_last) begin
                n_active = 1'b0;
            end else begin
                n_rest = quot;
                n_pos  = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_active <= n_active;
            r_pos    <= n_pos;
            r_strobe <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rest  <= n_rest;
        r_addr  <= cltd_pkg::ADDR_W'(r_pos) + cltd_pkg::ADDR_W'(1);
        r_value <= code;
        r_last  <= at_last;
    end

    assign o_strobe        = r_strobe;
    assign o_digit_address = r_addr;
    assign o_digit_value   = r_value;
    assign o_last_write    = r_last;

    `CLTD_ASSERT(a_last_addr, i_clk, i_rst_n,
        o_strobe && o_last_write |->
            o_digit_address == cltd_pkg::ADDR_W'(cltd_pkg::NUM_DIGITS),
        "final write not at top address")
    `CLTD_ASSERT(a_run_steps, i_clk, i_rst_n,
        o_strobe && !o_last_write |=>
            o_strobe && o_digit_address == $past(o_digit_address) + 1'b1,
        "digit run broken or out of order")
    `CLTD_NEVER(a_bad_code, i_clk, i_rst_n,
        o_strobe && (o_digit_value[6:4] != 3'b000 ||
                     (o_digit_value[3:0] > 4'd9 &&
                      o_digit_value[3:0] != cltd_pkg::BLANK_CODE)),
        "digit value holds an illegal code")

endmodule

/* rtl/core/count_to_led_digit_writes_core.sv */
// Top level of the count to LED digit writes core.
// Depends on cltd_pkg, cltd_queue and cltd_digit_seq.
//
// Usage
//   Command side: drive i_count_value and raise start; the count is taken
//   at a rising edge where start is high and busy is low. busy rises only
//   while the two-entry count queue is full.
//   Result side: every count yields NUM_DIGITS (8) display register writes,
//   one beat per cycle marked by o_strobe, at o_digit_address 1 upward,
//   least significant digit first. o_digit_value carries the digit in its
//   low nibble, the separator point in bit 7 on addresses 4 and 7, and
//   code 15 with no point for a leading zero. o_last_write flags the beat
//   at the top address. Decimal digits above the eighth are dropped.
// Timing
//   When the sequencer is idle, an accepted count passes the queue, the
//   sequencer's working registers and its output registers before its first
//   beat is on the ports. The sequencer runs one divide-by-ten (a 32x32
//   reciprocal multiply) per cycle; runs follow each other with no gap.
// Reset and stalls
//   Synchronous reset empties the queue and stops any run in progress;
//   no beats come out until new counts arrive. The receiver cannot stall:
//   every beat is taken in the cycle it is shown.
module count_to_led_digit_writes_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cltd_pkg::COUNT_W-1:0]  i_count_value,
    output logic                          o_strobe,
    output logic [cltd_pkg::ADDR_W-1:0]   o_digit_address,
    output logic [cltd_pkg::VALUE_W-1:0]  o_digit_value,
    output logic                          o_last_write
);

    cltd_pkg::t_q_status          q_status;
    logic [cltd_pkg::COUNT_W-1:0] q_head;
    logic                         q_push;
    logic                         q_pop;

    // front: a count is queued on every accepted command beat
    assign busy   = q_status.full;
    assign q_push = start && !busy;

    cltd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (i_count_value),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    // back: pulls counts and emits the digit writes
    cltd_digit_seq u_digit_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_status      (q_status),
        .i_head          (q_head),
        .o_pop           (q_pop),
        .o_strobe        (o_strobe),
        .o_digit_address (o_digit_address),
        .o_digit_value   (o_digit_value),
        .o_last_write    (o_last_write)
    );

endmodule
